// ===== sv/wedt_pkg.sv =====
`default_nettype none
package wedt_pkg;

   // Sizing
   localparam int MAX_LEN   = 32;
   localparam int ALPHABET  = 26;
   localparam int COST_BITS = 8;

   localparam int DIST_W    = 14;
   localparam int LET_W     = 5;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int POS_W     = $clog2(MAX_LEN);
   localparam int ALPHA_W   = $clog2(ALPHABET);
   localparam int PAIR_W    = $clog2(ALPHABET * ALPHABET);
   localparam int BANK_W    = 2;
   localparam int ROW_AW    = BANK_W + LEN_W;
   localparam int ROW_DEPTH = 3 * (2 ** LEN_W);
   localparam int SUM_W     = ((DIST_W > COST_BITS) ? DIST_W : COST_BITS) + 1;

   localparam logic [DIST_W-1:0] DIST_MAX  = '1;
   localparam logic [LET_W-1:0]  ALPHA_LET = LET_W'(ALPHABET);
   localparam logic [LEN_W-1:0]  FULL_LEN  = LEN_W'(MAX_LEN);

   // Request actions
   localparam logic [1:0] ACT_COST   = 2'd0;
   localparam logic [1:0] ACT_SOURCE = 2'd1;
   localparam logic [1:0] ACT_TARGET = 2'd2;

   // Cost tables
   localparam logic [1:0] TBL_INS = 2'd0;
   localparam logic [1:0] TBL_DEL = 2'd1;
   localparam logic [1:0] TBL_SUB = 2'd2;
   localparam logic [1:0] TBL_TRA = 2'd3;

   // Datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
   localparam logic [OP_W-1:0] OP_BINIT = 4'd1;
   localparam logic [OP_W-1:0] OP_BREAD = 4'd2;
   localparam logic [OP_W-1:0] OP_BCOST = 4'd3;
   localparam logic [OP_W-1:0] OP_BACC  = 4'd4;
   localparam logic [OP_W-1:0] OP_RSRC  = 4'd5;
   localparam logic [OP_W-1:0] OP_RCOST = 4'd6;
   localparam logic [OP_W-1:0] OP_RINIT = 4'd7;
   localparam logic [OP_W-1:0] OP_CREAD = 4'd8;
   localparam logic [OP_W-1:0] OP_CCOST = 4'd9;
   localparam logic [OP_W-1:0] OP_CCELL = 4'd10;
   localparam logic [OP_W-1:0] OP_DONE  = 4'd11;

   typedef struct packed {
      logic            load;
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic go;
      logic m_zero;
      logic n_zero;
      logic j_end;
      logic i_end;
   } status_type;

   // Add a cost to a distance, saturating at the top code
   function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                 input logic [COST_BITS-1:0] b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      return (s > SUM_W'(DIST_MAX)) ? DIST_MAX : s[DIST_W-1:0];
   endfunction

   // Flat index of a letter pair table
   function automatic logic [PAIR_W-1:0] pair_index(input logic [LET_W-1:0] a,
                                                    input logic [LET_W-1:0] b);
      return PAIR_W'(a) * PAIR_W'(ALPHABET) + PAIR_W'(b);
   endfunction

endpackage
`default_nettype wire

// ===== sv/wedt_req_if.sv =====
`default_nettype none
interface wedt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [1:0] table_select;
   logic [4:0] row_letter;
   logic [4:0] col_letter;
   logic [7:0] cost_value;
   logic [4:0] letter;
   logic       last;

   modport source (output valid, action, table_select, row_letter, col_letter,
                   cost_value, letter, last, input ready);
   modport sink (input valid, action, table_select, row_letter, col_letter,
                 cost_value, letter, last, output ready);
endinterface
`default_nettype wire

// ===== sv/wedt_rsp_if.sv =====
`default_nettype none
interface wedt_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] distance;
   logic        too_long;

   modport source (output valid, distance, too_long, input ready);
   modport sink (input valid, distance, too_long, output ready);
endinterface
`default_nettype wire

// ===== sv/wedt_ctrl.sv =====
`default_nettype none
module wedt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  wedt_pkg::status_type   status,
   output wedt_pkg::cmd_type      cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BINIT = 4'd1;
   localparam logic [3:0] S_BREAD = 4'd2;
   localparam logic [3:0] S_BCOST = 4'd3;
   localparam logic [3:0] S_BACC  = 4'd4;
   localparam logic [3:0] S_RSRC  = 4'd5;
   localparam logic [3:0] S_RCOST = 4'd6;
   localparam logic [3:0] S_RINIT = 4'd7;
   localparam logic [3:0] S_CREAD = 4'd8;
   localparam logic [3:0] S_CCOST = 4'd9;
   localparam logic [3:0] S_CCELL = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;
   localparam logic [3:0] S_RESP  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       xfer;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign xfer      = req_valid && req_ready;

   // Sequence the table walk
   always_comb begin
      state_in = state_ff;
      cmd.load = xfer;
      cmd.op   = wedt_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (xfer && status.go) state_in = S_BINIT;
         end
         S_BINIT: begin
            cmd.op = wedt_pkg::OP_BINIT;
            if (!status.m_zero)     state_in = S_BREAD;
            else if (status.n_zero) state_in = S_DONE;
            else                    state_in = S_RSRC;
         end
         S_BREAD: begin
            cmd.op   = wedt_pkg::OP_BREAD;
            state_in = S_BCOST;
         end
         S_BCOST: begin
            cmd.op   = wedt_pkg::OP_BCOST;
            state_in = S_BACC;
         end
         S_BACC: begin
            cmd.op = wedt_pkg::OP_BACC;
            if (!status.j_end)      state_in = S_BREAD;
            else if (status.n_zero) state_in = S_DONE;
            else                    state_in = S_RSRC;
         end
         S_RSRC: begin
            cmd.op   = wedt_pkg::OP_RSRC;
            state_in = S_RCOST;
         end
         S_RCOST: begin
            cmd.op   = wedt_pkg::OP_RCOST;
            state_in = S_RINIT;
         end
         S_RINIT: begin
            cmd.op = wedt_pkg::OP_RINIT;
            if (!status.m_zero)    state_in = S_CREAD;
            else if (status.i_end) state_in = S_DONE;
            else                   state_in = S_RSRC;
         end
         S_CREAD: begin
            cmd.op   = wedt_pkg::OP_CREAD;
            state_in = S_CCOST;
         end
         S_CCOST: begin
            cmd.op   = wedt_pkg::OP_CCOST;
            state_in = S_CCELL;
         end
         S_CCELL: begin
            cmd.op = wedt_pkg::OP_CCELL;
            if (!status.j_end)     state_in = S_CREAD;
            else if (status.i_end) state_in = S_DONE;
            else                   state_in = S_RSRC;
         end
         S_DONE: begin
            cmd.op   = wedt_pkg::OP_DONE;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

// ===== sv/wedt_dp.sv =====
`default_nettype none
module wedt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  wedt_pkg::cmd_type             cmd,
   output wedt_pkg::status_type          status,
   input  logic [1:0]                    req_action,
   input  logic [1:0]                    req_table_select,
   input  logic [4:0]                    req_row_letter,
   input  logic [4:0]                    req_col_letter,
   input  logic [7:0]                    req_cost_value,
   input  logic [4:0]                    req_letter,
   input  logic                          req_last,
   output logic [wedt_pkg::DIST_W-1:0]   rsp_distance,
   output logic                          rsp_too_long
);

   localparam int CB = wedt_pkg::COST_BITS;
   localparam int DW = wedt_pkg::DIST_W;
   localparam int LW = wedt_pkg::LET_W;
   localparam int NW = wedt_pkg::LEN_W;
   localparam int BW = wedt_pkg::BANK_W;
   localparam int AW = wedt_pkg::ALPHA_W;

   // Storage
   logic [CB-1:0] ins_mem [0:wedt_pkg::ALPHABET-1];
   logic [CB-1:0] del_mem [0:wedt_pkg::ALPHABET-1];
   logic [CB-1:0] sub_mem [0:wedt_pkg::ALPHABET*wedt_pkg::ALPHABET-1];
   logic [CB-1:0] tra_mem [0:wedt_pkg::ALPHABET*wedt_pkg::ALPHABET-1];
   logic [LW-1:0] src_mem [0:wedt_pkg::MAX_LEN-1];
   logic [LW-1:0] tgt_mem [0:wedt_pkg::MAX_LEN-1];
   logic [DW-1:0] row_mem [0:wedt_pkg::ROW_DEPTH-1];

   logic [NW-1:0] src_len_ff, tgt_len_ff;
   logic          ovf_ff;
   logic [NW-1:0] i_ff, j_ff;
   logic [BW-1:0] bpp_ff, bpr_ff, bcu_ff;
   logic [DW-1:0] acc_ff, diag_ff, pra_ff, ppb_ff;
   logic [LW-1:0] src_ff, sprev_ff, tl_ff, tlprev_ff;
   logic [CB-1:0] ins_ff, del_ff, sub_ff, tra_ff;
   logic [DW-1:0] dist_ff;
   logic          too_long_ff;

   logic          load, src_full, tgt_full;
   logic          row_ok, col_ok, src_ok, tl_ok, sprev_ok, tra_ok, row_end;
   logic [NW-1:0] jm1, jm2, im1;
   logic [CB-1:0] ins_price, del_price, sub_price, tra_price;
   logic [DW-1:0] cu0, c_ins, c_del, c_sub, c_tra, best;
   logic          wr_en;
   logic [wedt_pkg::ROW_AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;

   assign load     = cmd.load;
   assign src_full = (src_len_ff == wedt_pkg::FULL_LEN);
   assign tgt_full = (tgt_len_ff == wedt_pkg::FULL_LEN);
   assign row_ok   = (req_row_letter < wedt_pkg::ALPHA_LET);
   assign col_ok   = (req_col_letter < wedt_pkg::ALPHA_LET);
   assign src_ok   = (src_ff < wedt_pkg::ALPHA_LET);
   assign tl_ok    = (tl_ff < wedt_pkg::ALPHA_LET);
   assign sprev_ok = (sprev_ff < wedt_pkg::ALPHA_LET);
   assign jm1      = j_ff - NW'(1);
   assign jm2      = j_ff - NW'(2);
   assign im1      = i_ff - NW'(1);

   assign status.go     = (req_action == wedt_pkg::ACT_TARGET) && req_last;
   assign status.m_zero = (tgt_len_ff == '0);
   assign status.n_zero = (src_len_ff == '0);
   assign status.j_end  = (j_ff == tgt_len_ff);
   assign status.i_end  = (i_ff == src_len_ff);

   // Letters outside the alphabet price at zero
   assign ins_price = tl_ok ? ins_ff : '0;
   assign del_price = src_ok ? del_ff : '0;
   assign sub_price = (src_ok && tl_ok) ? sub_ff : '0;
   assign tra_price = (src_ok && sprev_ok) ? tra_ff : '0;

   // One table cell: cheapest of the four moves
   assign cu0    = wedt_pkg::sat_add(pra_ff, del_price);
   assign c_ins  = wedt_pkg::sat_add(acc_ff, ins_price);
   assign c_del  = wedt_pkg::sat_add(pra_ff, del_price);
   assign c_sub  = wedt_pkg::sat_add(diag_ff, sub_price);
   assign c_tra  = wedt_pkg::sat_add(ppb_ff, tra_price);
   assign tra_ok = (i_ff > NW'(1)) && (j_ff > NW'(1)) &&
                   (src_ff == tlprev_ff) && (sprev_ff == tl_ff);

   always_comb begin
      best = c_ins;
      if (c_del < best) best = c_del;
      if (c_sub < best) best = c_sub;
      if (tra_ok && (c_tra < best)) best = c_tra;
   end

   assign row_end = ((cmd.op == wedt_pkg::OP_RINIT) && status.m_zero) ||
                    ((cmd.op == wedt_pkg::OP_CCELL) && status.j_end);

   // Write cost entries
   always_ff @(posedge clock) begin
      if (load && (req_action == wedt_pkg::ACT_COST) && row_ok) begin
         unique case (req_table_select)
            wedt_pkg::TBL_INS: ins_mem[req_row_letter[AW-1:0]] <= CB'(req_cost_value);
            wedt_pkg::TBL_DEL: del_mem[req_row_letter[AW-1:0]] <= CB'(req_cost_value);
            wedt_pkg::TBL_SUB: begin
               if (col_ok)
                  sub_mem[wedt_pkg::pair_index(req_row_letter, req_col_letter)] <=
                     CB'(req_cost_value);
            end
            wedt_pkg::TBL_TRA: begin
               if (col_ok)
                  tra_mem[wedt_pkg::pair_index(req_row_letter, req_col_letter)] <=
                     CB'(req_cost_value);
            end
            default: ;
         endcase
      end
   end

   // Append letters
   always_ff @(posedge clock) begin
      if (load && (req_action == wedt_pkg::ACT_SOURCE) && !src_full)
         src_mem[src_len_ff[wedt_pkg::POS_W-1:0]] <= req_letter;
      if (load && (req_action == wedt_pkg::ACT_TARGET) && !tgt_full)
         tgt_mem[tgt_len_ff[wedt_pkg::POS_W-1:0]] <= req_letter;
   end

   // Track lengths and the dropped-letter flag
   always_ff @(posedge clock) begin
      if (reset) begin
         src_len_ff <= '0;
         tgt_len_ff <= '0;
         ovf_ff     <= 1'b0;
      end else if (cmd.op == wedt_pkg::OP_DONE) begin
         src_len_ff <= '0;
         tgt_len_ff <= '0;
         ovf_ff     <= 1'b0;
      end else if (load) begin
         if (req_action == wedt_pkg::ACT_SOURCE) begin
            if (src_full) ovf_ff <= 1'b1;
            else          src_len_ff <= src_len_ff + NW'(1);
         end else if (req_action == wedt_pkg::ACT_TARGET) begin
            if (tgt_full) ovf_ff <= 1'b1;
            else          tgt_len_ff <= tgt_len_ff + NW'(1);
         end
      end
   end

   // Row store: one write, two reads
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {bcu_ff, j_ff};
      wr_data = best;
      unique case (cmd.op)
         wedt_pkg::OP_BINIT: begin
            wr_en   = 1'b1;
            wr_addr = {BW'(1), NW'(0)};
            wr_data = '0;
         end
         wedt_pkg::OP_BACC: begin
            wr_en   = 1'b1;
            wr_addr = {bpr_ff, j_ff};
            wr_data = c_ins;
         end
         wedt_pkg::OP_RINIT: begin
            wr_en   = 1'b1;
            wr_addr = {bcu_ff, NW'(0)};
            wr_data = cu0;
         end
         wedt_pkg::OP_CCELL: wr_en = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) row_mem[wr_addr] <= wr_data;
      if (cmd.op == wedt_pkg::OP_RCOST) pra_ff <= row_mem[{bpr_ff, NW'(0)}];
      if (cmd.op == wedt_pkg::OP_CREAD) begin
         pra_ff <= row_mem[{bpr_ff, j_ff}];
         ppb_ff <= row_mem[{bpp_ff, jm2}];
      end
   end

   // Walk the table
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         wedt_pkg::OP_BINIT: begin
            i_ff   <= NW'(1);
            j_ff   <= NW'(1);
            bpp_ff <= BW'(0);
            bpr_ff <= BW'(1);
            bcu_ff <= BW'(2);
            acc_ff <= '0;
         end
         wedt_pkg::OP_BREAD: tl_ff <= tgt_mem[jm1[wedt_pkg::POS_W-1:0]];
         wedt_pkg::OP_BCOST: ins_ff <= ins_mem[tl_ff[AW-1:0]];
         wedt_pkg::OP_BACC: begin
            acc_ff <= c_ins;
            j_ff   <= j_ff + NW'(1);
         end
         wedt_pkg::OP_RSRC: src_ff <= src_mem[im1[wedt_pkg::POS_W-1:0]];
         wedt_pkg::OP_RCOST: begin
            del_ff <= del_mem[src_ff[AW-1:0]];
            tra_ff <= tra_mem[wedt_pkg::pair_index(src_ff, sprev_ff)];
         end
         wedt_pkg::OP_RINIT: begin
            acc_ff  <= cu0;
            diag_ff <= pra_ff;
            j_ff    <= NW'(1);
         end
         wedt_pkg::OP_CREAD: begin
            tl_ff     <= tgt_mem[jm1[wedt_pkg::POS_W-1:0]];
            tlprev_ff <= tl_ff;
         end
         wedt_pkg::OP_CCOST: begin
            ins_ff <= ins_mem[tl_ff[AW-1:0]];
            sub_ff <= sub_mem[wedt_pkg::pair_index(src_ff, tl_ff)];
         end
         wedt_pkg::OP_CCELL: begin
            acc_ff  <= best;
            diag_ff <= pra_ff;
            j_ff    <= j_ff + NW'(1);
         end
         wedt_pkg::OP_DONE: begin
            dist_ff     <= acc_ff;
            too_long_ff <= ovf_ff;
         end
         default: ;
      endcase
      // Rotate row banks at the end of each source row
      if (row_end) begin
         i_ff     <= i_ff + NW'(1);
         bpp_ff   <= bpr_ff;
         bpr_ff   <= bcu_ff;
         bcu_ff   <= bpp_ff;
         sprev_ff <= src_ff;
      end
   end

   assign rsp_distance = dist_ff;
   assign rsp_too_long = too_long_ff;

endmodule
`default_nettype wire

// ===== sv/weighted_edit_distance_transpose_core.sv =====
// Channel   Dir  Handshake        Payload
// req_chan  in   valid / ready    action, table_select, row_letter, col_letter,
//                                 cost_value, letter, last
// rsp_chan  out  valid / ready    distance, too_long
//
// Load items (cost writes, letter appends) are accepted whenever the core is idle.
// A target letter with last set runs the table: the border row, then a row
// per source letter, then a step that registers the result; each cell is a
// letter read, a cost-table read and a compare through registered memories.
// The result is held until rsp_chan transfers it; no request is taken meanwhile.
// Synchronous reset clears the lengths, the overflow flag and the sequencer.
`default_nettype none
module weighted_edit_distance_transpose_core (
   input  logic          clock,
   input  logic          reset,
   wedt_req_if.sink      req_chan,
   wedt_rsp_if.source    rsp_chan
);

   wedt_pkg::cmd_type    cmd;
   wedt_pkg::status_type status;

   wedt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wedt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_chan.action),
      .req_table_select (req_chan.table_select),
      .req_row_letter   (req_chan.row_letter),
      .req_col_letter   (req_chan.col_letter),
      .req_cost_value   (req_chan.cost_value),
      .req_letter       (req_chan.letter),
      .req_last         (req_chan.last),
      .rsp_distance     (rsp_chan.distance),
      .rsp_too_long     (rsp_chan.too_long)
   );

endmodule
`default_nettype wire
